// ----- rtl/core/efrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package efrc_pkg;

  localparam logic [7:0] CH_OPEN    = 8'h3C;
  localparam logic [7:0] CH_CLOSE   = 8'h3E;
  localparam logic [7:0] CH_ESC     = 8'h3D;
  localparam logic [7:0] CH_ROUTE   = 8'h6F;
  localparam logic [7:0] CH_ENABLE  = 8'h45;
  localparam logic [7:0] CH_DISABLE = 8'h65;

  localparam logic [4:0] HEX_NONE = 5'h1F;

  typedef enum logic [1:0] {
    KIND_ROUTE = 2'd0,
    KIND_ON    = 2'd1,
    KIND_OFF   = 2'd2,
    KIND_NONE  = 2'd3
  } cmd_kind_t;

  // ASCII hex digit to 0..15, HEX_NONE (-1) otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else begin
      v = HEX_NONE;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/escaped_frame_route_commander_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted input word has its result word in the output register in the cycle after it is accepted.
// Throughput: one word per cycle unless stalled; frame state updates in the accept cycle.
// The output register frees in the cycle it is taken, so stall passes back only when full.
// Reset (rst_n low, synchronous): idle, no escape, no payload, relays enabled,
// output register empty.
module escaped_frame_route_commander_unit #(
  parameter int ROUTE_ENTRIES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_echo_byte,
  output logic                   out_cmd_done,
  output efrc_pkg::cmd_kind_t    out_cmd_kind,
  output logic                   out_map_written,
  output logic [2:0]             out_out_index,
  output logic signed [4:0]      out_in_value,
  output logic                   out_relays_on
);
  import efrc_pkg::*;

  logic       accept;
  logic       frame_active_r, frame_active_nxt;
  logic       escape_r, escape_nxt;
  logic [1:0] byte_count_r, byte_count_nxt;
  logic [7:0] fb0_r, fb1_r, fb2_r;
  logic       relay_en_r, relay_en_nxt;

  logic       out_valid_r;
  logic [7:0] echo_r;
  logic       done_r, done_nxt;
  cmd_kind_t  kind_r, kind_nxt;
  logic       written_r, written_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic [4:0] ival_r, ival_nxt;

  logic [4:0] hex_o;
  logic [4:0] hex_v;
  logic       store;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign hex_o = (byte_count_r >= 2'd2) ? hex_value(fb1_r) : HEX_NONE;
  assign hex_v = (byte_count_r == 2'd3) ? hex_value(fb2_r) : HEX_NONE;

  always_comb begin
    frame_active_nxt = frame_active_r;
    escape_nxt       = escape_r;
    byte_count_nxt   = byte_count_r;
    relay_en_nxt     = relay_en_r;
    done_nxt         = 1'b0;
    kind_nxt         = KIND_ROUTE;
    written_nxt      = 1'b0;
    oidx_nxt         = 3'd0;
    ival_nxt         = 5'd0;
    store            = 1'b0;
    if (!frame_active_r) begin
      if (in_rx_byte == CH_OPEN) begin
        frame_active_nxt = 1'b1;
        byte_count_nxt   = 2'd0;
        escape_nxt       = 1'b0;
      end
    end else if (!escape_r && in_rx_byte == CH_OPEN) begin
      byte_count_nxt = 2'd0;
    end else if (!escape_r && in_rx_byte == CH_CLOSE) begin
      frame_active_nxt = 1'b0;
      done_nxt         = 1'b1;
      if (byte_count_r == 2'd0) begin
        kind_nxt = KIND_NONE;
      end else if (fb0_r == CH_ROUTE) begin
        kind_nxt = KIND_ROUTE;
        if (hex_o != HEX_NONE && 32'(hex_o) < ROUTE_ENTRIES) begin
          written_nxt = 1'b1;
          oidx_nxt    = hex_o[2:0];
          ival_nxt    = hex_v;
        end
      end else if (fb0_r == CH_ENABLE) begin
        kind_nxt     = KIND_ON;
        relay_en_nxt = 1'b1;
      end else if (fb0_r == CH_DISABLE) begin
        kind_nxt     = KIND_OFF;
        relay_en_nxt = 1'b0;
      end else begin
        kind_nxt = KIND_NONE;
      end
    end else if (!escape_r && in_rx_byte == CH_ESC) begin
      escape_nxt = 1'b1;
    end else begin
      if (byte_count_r != 2'd3) begin
        store          = 1'b1;
        byte_count_nxt = byte_count_r + 2'd1;
      end
      escape_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      escape_r       <= 1'b0;
      byte_count_r   <= 2'd0;
      relay_en_r     <= 1'b1;
    end else if (accept) begin
      frame_active_r <= frame_active_nxt;
      escape_r       <= escape_nxt;
      byte_count_r   <= byte_count_nxt;
      relay_en_r     <= relay_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      case (byte_count_r)
        2'd0:    fb0_r <= in_rx_byte;
        2'd1:    fb1_r <= in_rx_byte;
        default: fb2_r <= in_rx_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      echo_r    <= in_rx_byte;
      done_r    <= done_nxt;
      kind_r    <= kind_nxt;
      written_r <= written_nxt;
      oidx_r    <= oidx_nxt;
      ival_r    <= ival_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_byte   = echo_r;
  assign out_cmd_done    = done_r;
  assign out_cmd_kind    = kind_r;
  assign out_map_written = written_r;
  assign out_out_index   = oidx_r;
  assign out_in_value    = ival_r;
  assign out_relays_on   = relay_en_r;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import efrc_pkg::*;

  localparam int ROUTES = 8;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [7:0]        echo;
    logic              done;
    cmd_kind_t         kind;
    logic              wr;
    logic [2:0]        idx;
    logic signed [4:0] val;
    logic              relays;
  } reply_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       fixed;
    reply_t     want;
  } script_row_t;

  localparam reply_t NO_REPLY = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_echo_byte;
  logic              out_cmd_done;
  cmd_kind_t         out_cmd_kind;
  logic              out_map_written;
  logic [2:0]        out_out_index;
  logic signed [4:0] out_in_value;
  logic              out_relays_on;

  escaped_frame_route_commander_unit #(.ROUTE_ENTRIES(ROUTES)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_echo_byte   (out_echo_byte),
    .out_cmd_done    (out_cmd_done),
    .out_cmd_kind    (out_cmd_kind),
    .out_map_written (out_map_written),
    .out_out_index   (out_out_index),
    .out_in_value    (out_in_value),
    .out_relays_on   (out_relays_on)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // directed words; closing words and quiet bytes carry a typed reply
  script_row_t script [26] = '{
    '{8'h00, 1'b1, '{8'h00, 1'b0, KIND_ROUTE, 1'b0, 3'd0, 5'sd0, 1'b1}},
    '{8'hFF, 1'b1, '{8'hFF, 1'b0, KIND_ROUTE, 1'b0, 3'd0, 5'sd0, 1'b1}},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b0, KIND_ROUTE, 1'b0, 3'd0, 5'sd0, 1'b1}},
    '{CH_OPEN, 1'b1, '{CH_OPEN, 1'b0, KIND_ROUTE, 1'b0, 3'd0, 5'sd0, 1'b1}},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b1, KIND_NONE, 1'b0, 3'd0, 5'sd0, 1'b1}},
    '{CH_OPEN, 1'b0, NO_REPLY},
    '{CH_DISABLE, 1'b0, NO_REPLY},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b1, KIND_OFF, 1'b0, 3'd0, 5'sd0, 1'b0}},
    '{CH_OPEN, 1'b0, NO_REPLY},
    '{CH_ROUTE, 1'b0, NO_REPLY},
    '{8'h37, 1'b0, NO_REPLY},
    '{8'h46, 1'b0, NO_REPLY},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b1, KIND_ROUTE, 1'b1, 3'd7, 5'sd15, 1'b0}},
    '{CH_OPEN, 1'b0, NO_REPLY},
    '{CH_ROUTE, 1'b0, NO_REPLY},
    '{8'h30, 1'b0, NO_REPLY},
    '{CH_OPEN, 1'b0, NO_REPLY},
    '{CH_ENABLE, 1'b0, NO_REPLY},
    '{CH_ESC, 1'b0, NO_REPLY},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b0, KIND_ROUTE, 1'b0, 3'd0, 5'sd0, 1'b0}},
    '{8'h78, 1'b0, NO_REPLY},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b1, KIND_ON, 1'b0, 3'd0, 5'sd0, 1'b1}},
    '{CH_OPEN, 1'b0, NO_REPLY},
    '{CH_ROUTE, 1'b0, NO_REPLY},
    '{8'h33, 1'b0, NO_REPLY},
    '{CH_CLOSE, 1'b1, '{CH_CLOSE, 1'b1, KIND_ROUTE, 1'b1, 3'd3, HEX_NONE, 1'b1}}
  };

  // parser state mirror
  logic       in_frame = 1'b0;
  logic       esc_wait = 1'b0;
  int         kept = 0;
  logic [7:0] payload [3];
  logic       relays_en = 1'b1;

  reply_t replies [$];
  int     errors = 0;
  int     parsed_words = 0;
  int     quiet = 0;
  int     snd_pct = 0;
  int     rcv_pct = 0;
  bit     hold_req = 0;
  int     hold_left = 0;
  bit     row_fixed = 0;
  reply_t row_want = '0;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic reply_t parse_byte(logic [7:0] c);
    reply_t r;
    int o, v;
    r = '0;
    r.kind = KIND_ROUTE;
    r.echo = c;
    if (!in_frame) begin
      if (c == CH_OPEN) begin
        in_frame = 1'b1;
        kept = 0;
        esc_wait = 1'b0;
      end
    end else if (!esc_wait && c == CH_OPEN) begin
      kept = 0;
    end else if (!esc_wait && c == CH_CLOSE) begin
      in_frame = 1'b0;
      r.done = 1'b1;
      if (kept == 0) begin
        r.kind = KIND_NONE;
      end else if (payload[0] == CH_ROUTE) begin
        o = (kept >= 2) ? hex_digit(payload[1]) : -1;
        v = (kept >= 3) ? hex_digit(payload[2]) : -1;
        if (o >= 0 && o < ROUTES) begin
          r.wr = 1'b1;
          r.idx = o[2:0];
          r.val = v[4:0];
        end
      end else if (payload[0] == CH_ENABLE) begin
        r.kind = KIND_ON;
        relays_en = 1'b1;
      end else if (payload[0] == CH_DISABLE) begin
        r.kind = KIND_OFF;
        relays_en = 1'b0;
      end else begin
        r.kind = KIND_NONE;
      end
    end else if (!esc_wait && c == CH_ESC) begin
      esc_wait = 1'b1;
    end else begin
      if (kept < 3) begin
        payload[kept] = c;
        kept++;
      end
      esc_wait = 1'b0;
    end
    r.relays = relays_en;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    reply_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_echo_byte, out_cmd_done, out_cmd_kind, out_map_written,
                out_out_index, out_in_value, out_relays_on};
        if (replies.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = replies.pop_front();
          check_field("echo_byte", want.echo, got.echo);
          check_field("cmd_done", want.done, got.done);
          check_field("cmd_kind", int'(want.kind), int'(got.kind));
          check_field("map_written", want.wr, got.wr);
          check_field("out_index", want.idx, got.idx);
          check_field("in_value", $signed(want.val), $signed(got.val));
          check_field("relays_on", want.relays, got.relays);
        end
      end
      if (in_valid && !in_stall) begin
        parsed_words++;
        pred = parse_byte(in_rx_byte);
        replies.push_back(row_fixed ? row_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_pct);
      end
    end
  end

  task automatic send_word(logic [7:0] b, bit fixed, reply_t want);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < snd_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    row_fixed = fixed;
    row_want = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [7:0] payload_byte(int pos);
    int r, n;
    logic [7:0] b;
    r = $urandom_range(99);
    n = $urandom_range(21);
    if (pos == 0) begin
      if (r < 35) b = CH_ROUTE;
      else if (r < 55) b = CH_ENABLE;
      else if (r < 75) b = CH_DISABLE;
      else b = 8'($urandom_range(255));
    end else if (r < 80) begin
      if (n < 10) b = 8'(8'h30 + n);
      else if (n < 16) b = 8'(8'h41 + n - 10);
      else b = 8'(8'h61 + n - 16);
    end else begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic send_frame();
    int len;
    logic [7:0] b;
    send_word(CH_OPEN, 1'b0, NO_REPLY);
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 2)) send_word(payload_byte(0), 1'b0, NO_REPLY);
      send_word(CH_OPEN, 1'b0, NO_REPLY);
    end
    len = ($urandom_range(99) < 70) ? 3 : $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      b = payload_byte(i);
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0: b = CH_OPEN;
          1: b = CH_CLOSE;
          2: b = CH_ESC;
          default: ;
        endcase
        send_word(CH_ESC, 1'b0, NO_REPLY);
      end
      send_word(b, 1'b0, NO_REPLY);
    end
    if ($urandom_range(99) < 92) send_word(CH_CLOSE, 1'b0, NO_REPLY);
    repeat ($urandom_range(0, 2)) send_word(8'($urandom_range(255)), 1'b0, NO_REPLY);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    snd_pct = 37;
    rcv_pct = 86;
    foreach (script[i]) send_word(script[i].rx, script[i].fixed, script[i].want);
    while (parsed_words < 420) send_frame();
    snd_pct = 86;
    rcv_pct = 37;
    while (parsed_words < 820) send_frame();
    snd_pct = 0;
    rcv_pct = 0;
    hold_req = 1;
    while (parsed_words < 1220) send_frame();
    in_valid <= 1'b0;
    while (replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
